// File: sv/mtvb_pkg.sv
package mtvb_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BASE   = 2'd1,
        CMD_TARGET = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // per-lane operation
    typedef enum logic [1:0] {
        LANE_NOP  = 2'd0,
        LANE_BASE = 2'd1,
        LANE_ADD  = 2'd2
    } lane_op_t;

    typedef struct packed {
        logic     adv;
        lane_op_t op;
    } lane_ctrl_t;

    localparam int unsigned NUM_LANES  = 8;
    localparam int unsigned COMP_W     = 32;
    localparam int unsigned WEIGHT_W   = 16;
    localparam int unsigned SLOT_W     = 16;
    localparam int unsigned FRAC_SHIFT = 12;
    localparam int unsigned S_TDATA_W  = 288;
    localparam int unsigned M_TDATA_W  = 272;

    localparam logic signed [WEIGHT_W-1:0] GAIN_RESET = 16'sd4096;

endpackage

// File: sv/mtvb_wgt_table.sv
module mtvb_wgt_table #(
    parameter int MAX_TARGETS = 64,
    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
    input  logic                                    aclk,
    input  logic                                    rd_en,
    input  logic [IDX_W-1:0]                        rd_addr,
    input  logic                                    wr_en,
    input  logic [IDX_W-1:0]                        wr_addr,
    input  logic signed [mtvb_pkg::WEIGHT_W-1:0]    raw_weight,
    input  logic signed [mtvb_pkg::WEIGHT_W-1:0]    gain,
    output logic signed [mtvb_pkg::WEIGHT_W-1:0]    rd_weight
);

    logic signed [mtvb_pkg::WEIGHT_W-1:0] mem [MAX_TARGETS];

    logic signed [31:0]                   scaled_full;
    logic signed [19:0]                   scaled_shr;
    logic signed [mtvb_pkg::WEIGHT_W-1:0] wr_data;

    logic signed [mtvb_pkg::WEIGHT_W-1:0] rd_data_reg;
    logic signed [mtvb_pkg::WEIGHT_W-1:0] fwd_data_reg;
    logic                                 fwd_reg;

    // weight times gain, floor shift, clamp to 16 bits
    always_comb begin
        scaled_full = raw_weight * gain;
        scaled_shr  = scaled_full[31:12];
        if (scaled_shr[19:15] == 5'b00000 || scaled_shr[19:15] == 5'b11111) begin
            wr_data = scaled_shr[15:0];
        end else if (scaled_shr[19]) begin
            wr_data = 16'sh8000;
        end else begin
            wr_data = 16'sh7fff;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read with write-to-read bypass for a load just ahead of the target
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_weight = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

// File: sv/mtvb_lane.sv
module mtvb_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mtvb_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [mtvb_pkg::WEIGHT_W-1:0]  weight,
    input  logic signed [mtvb_pkg::COMP_W-1:0]    operand,
    output logic signed [mtvb_pkg::COMP_W-1:0]    acc
);

    mtvb_pkg::lane_op_t        op2_reg;
    logic signed [47:0]        data2_reg;
    logic signed [47:0]        data2_next;
    logic signed [35:0]        shifted;
    logic signed [36:0]        sum;
    logic signed [31:0]        acc_reg;
    logic signed [31:0]        acc_next;

    // product for a target, sign-extended base component otherwise
    always_comb begin
        if (ctrl.op == mtvb_pkg::LANE_ADD) begin
            data2_next = operand * weight;
        end else begin
            data2_next = 48'(operand);
        end
    end

    always_comb begin
        shifted = data2_reg[47:12];
        sum     = 37'(acc_reg) + 37'(shifted);
        acc_next = acc_reg;
        case (op2_reg)
            mtvb_pkg::LANE_BASE: begin
                acc_next = data2_reg[31:0];
            end
            mtvb_pkg::LANE_ADD: begin
                if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
                    acc_next = sum[31:0];
                end else if (sum[36]) begin
                    acc_next = 32'sh8000_0000;
                end else begin
                    acc_next = 32'sh7fff_ffff;
                end
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            data2_reg <= data2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op2_reg <= mtvb_pkg::LANE_NOP;
            acc_reg <= '0;
        end else if (ctrl.adv) begin
            op2_reg <= ctrl.op;
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: sv/morph_target_vertex_blend_core.sv
// blend-shape vertex accumulator
// input items arrive on the s_ stream, kind on s_tuser: load weight, base vertex,
// target offset, end vertex. only an end item produces a result on the m_ stream.
// weight_gain is written through cfg_wr_en / cfg_wr_data; the user must do so only
// while the block is idle, which the block itself does not enforce. pipeline: the
// accept cycle issues the weight table read, stage 1 has the weight and runs eight
// 32x16 multiplies, stage 2 adds into the accumulators with saturation. a weight
// load writes the table from stage 1; a target right behind it gets the new weight
// through a bypass around the table's registered read port. throughput is one item
// per clock while s_tready is high, set by the accumulate loop in each lane.
// after reset the accumulators are zero, the gain is 1.0 and the output is empty;
// the weight table holds nothing useful until loaded.
// the result register lets items keep flowing while a result waits; only a second
// end item reaching stage 2 while the result is still held stalls the pipeline and
// drops s_tready.
module morph_target_vertex_blend_core #(
    parameter int MAX_TARGETS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [mtvb_pkg::WEIGHT_W-1:0]       cfg_wr_data,    // weight_gain
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot, weight_value, pos_x, pos_y, pos_z, pos_w, nrm_x, nrm_y, nrm_z, nrm_w
    input  logic [mtvb_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [1:0]                          s_tuser,        // cmd
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // vertex_index, out_pos_x .. out_pos_w, out_nrm_x .. out_nrm_w
    output logic [mtvb_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int NL    = mtvb_pkg::NUM_LANES;
    localparam int CW    = mtvb_pkg::COMP_W;
    localparam int WW    = mtvb_pkg::WEIGHT_W;
    localparam int SW    = mtvb_pkg::SLOT_W;

    // config register
    logic signed [WW-1:0]       gain_reg;

    // input field split
    mtvb_pkg::cmd_t             in_cmd;
    logic [SW-1:0]              in_slot;
    logic                       in_range;

    // stage 1
    logic                       s1_valid_reg;
    mtvb_pkg::cmd_t             s1_cmd_reg;
    logic [SW-1:0]              s1_slot_reg;
    logic                       s1_range_reg;
    logic signed [WW-1:0]       s1_raw_reg;
    logic signed [CW-1:0]       s1_data_reg [NL];

    // stage 2 (end item bookkeeping; lanes hold the data)
    logic                       s2_end_reg;
    logic [SW-1:0]              s2_slot_reg;

    // result register
    logic                       out_valid_reg;
    logic [SW-1:0]              out_index_reg;
    logic signed [CW-1:0]       out_data_reg [NL];

    logic                       adv;
    logic                       accept;
    logic                       wr_en;
    logic signed [WW-1:0]       weight;
    mtvb_pkg::lane_ctrl_t       lane_ctrl;
    logic signed [CW-1:0]       acc [NL];

    assign in_cmd   = mtvb_pkg::cmd_t'(s_tuser);
    assign in_slot  = s_tdata[SW-1:0];
    assign in_range = {1'b0, in_slot} < (SW+1)'(MAX_TARGETS);

    // stall only when a second end item would overwrite a result not yet taken
    assign adv      = !(s2_end_reg && out_valid_reg && !m_tready);
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= mtvb_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg   <= in_cmd;
            s1_slot_reg  <= in_slot;
            s1_range_reg <= in_range;
            s1_raw_reg   <= s_tdata[2*SW-1:SW];
            for (int i = 0; i < NL; i++) begin
                s1_data_reg[i] <= s_tdata[32 + i*CW +: CW];
            end
        end
    end

    // weight loads commit from stage 1
    assign wr_en = adv && s1_valid_reg && s1_range_reg && (s1_cmd_reg == mtvb_pkg::CMD_LOAD);

    mtvb_wgt_table #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_wgt_table (
        .aclk       (aclk),
        .rd_en      (adv),
        .rd_addr    (in_slot[IDX_W-1:0]),
        .wr_en      (wr_en),
        .wr_addr    (s1_slot_reg[IDX_W-1:0]),
        .raw_weight (s1_raw_reg),
        .gain       (gain_reg),
        .rd_weight  (weight)
    );

    // lane operation for the item in stage 1
    always_comb begin
        lane_ctrl.adv = adv;
        lane_ctrl.op  = mtvb_pkg::LANE_NOP;
        if (s1_valid_reg) begin
            unique case (s1_cmd_reg)
                mtvb_pkg::CMD_BASE: begin
                    lane_ctrl.op = mtvb_pkg::LANE_BASE;
                end
                mtvb_pkg::CMD_TARGET: begin
                    lane_ctrl.op = s1_range_reg ? mtvb_pkg::LANE_ADD : mtvb_pkg::LANE_NOP;
                end
                default: begin
                    lane_ctrl.op = mtvb_pkg::LANE_NOP;
                end
            endcase
        end
    end

    // four position and four normal lanes
    for (genvar g = 0; g < NL; g++) begin : g_lane
        mtvb_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .weight  (weight),
            .operand (s1_data_reg[g]),
            .acc     (acc[g])
        );
    end

    // stage 2: end item waits here for the accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_end_reg <= 1'b0;
        end else if (adv) begin
            s2_end_reg <= s1_valid_reg && (s1_cmd_reg == mtvb_pkg::CMD_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_slot_reg <= s1_slot_reg;
        end
    end

    // result register: capture accumulators when the end item leaves stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && s2_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_end_reg) begin
            out_index_reg <= s2_slot_reg;
            for (int i = 0; i < NL; i++) begin
                out_data_reg[i] <= acc[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata[SW-1:0] = out_index_reg;
        for (int i = 0; i < NL; i++) begin
            m_tdata[SW + i*CW +: CW] = out_data_reg[i];
        end
    end

endmodule
